// File: src/rws_pkg.sv
// Shared widths, codes and word types of the roulette wheel selector.
package rws_pkg;

  // Field widths of the input and result words
  localparam int COST_W  = 16;
  localparam int DRAW_W  = 22;
  localparam int INDEX_W = 5;
  localparam int TOTAL_W = 22;

  // Weight of an entry: weight = max_cost + WEIGHT_MARGIN - cost; the worst entry gets WEIGHT_MARGIN
  localparam int WEIGHT_MARGIN = 5;

  // Defaults for the top-level parameters
  localparam int DEF_POP_SIZE  = 32;
  localparam int DEF_COST_BITS = 16;

  // Operation codes of an input word
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_PICKED = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

// File: src/rws_if.sv
// Valid/ready channel interfaces for the input and result words.
interface rws_in_if
  import rws_pkg::*;
();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [COST_W-1:0] cost_value;
  logic [DRAW_W-1:0] draw_value;

  modport source (output valid, output op, output cost_value, output draw_value,
                  input ready);
  modport sink   (input valid, input op, input cost_value, input draw_value,
                  output ready);
endinterface

interface rws_out_if
  import rws_pkg::*;
();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [INDEX_W-1:0] picked_index;
  logic [TOTAL_W-1:0] total_weight;

  modport source (output valid, output status, output picked_index,
                  output total_weight, input ready);
  modport sink   (input valid, input status, input picked_index,
                  input total_weight, output ready);
endinterface

// File: src/roulette_wheel_selector.sv
// Cost-based roulette wheel selector: cost store, marks, scan sequencer.
//
// Usage: in_ch carries words with op, cost_value and draw_value. A load word
// (op 0) appends one cost to the store; a draw word (op 1) walks the prefix
// sums of the weights (max_cost + 5 - cost) and marks the first unmarked
// entry whose prefix reaches draw_value. A load after draws starts a new set.
// out_ch returns one word per input word: status, picked_index and the
// current total weight.
// Sequence: a load goes from accept to S_DONE, which sets out_ch.valid. A draw
// goes to S_SCAN, steps through the entries up to the one it stops at, then to
// S_DONE; a draw on an empty store goes straight to S_DONE. The scan is paced
// by the single read port of the cost memory, which delivers one stored cost
// per cycle to the prefix adder.
// One word is in flight at a time: in_ch.ready rises again in the cycle the
// result is taken, so the next word is accepted at that same edge.
// Reset (rst_n low, synchronous) empties the store, clears all marks, the
// maximum, the sum and the draw phase; no clearing pass is needed.
// When out_ch stalls, the result holds in the output register and no new
// word is accepted until it is taken.
module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int POP_SIZE  = DEF_POP_SIZE,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  rws_in_if.sink    in_ch,
  rws_out_if.source out_ch
);

  // Stored cost width: input field is 16 bits, only the low COST_BITS of it kept (at most 16)
  localparam int CW   = (COST_BITS < COST_W) ? COST_BITS : COST_W;
  localparam int IW   = $clog2(POP_SIZE);
  localparam int CNTW = $clog2(POP_SIZE + 1);
  localparam int SUMW = CW + CNTW;
  localparam int PW   = CW + 1 + CNTW;
  localparam int CMPW = (PW > DRAW_W) ? PW : DRAW_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [CNTW-1:0]     count_r;
  logic [CW-1:0]       max_r;
  logic [SUMW-1:0]     sum_r;
  logic                drawing_r;
  logic [POP_SIZE-1:0] marks_r;
  logic [IW-1:0]       j_r;
  logic [PW-1:0]       prefix_r;
  logic [DRAW_W-1:0]   draw_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic [TOTAL_W-1:0]  out_total_r;

  // Cost memory, one read port with registered data
  logic [CW-1:0] mem [POP_SIZE];
  logic [CW-1:0] rd_data_r;

  logic            accept;
  logic            is_load;
  logic            full;
  logic [CW-1:0]   cost_in;
  logic [CNTW-1:0] base_count;
  logic [CW-1:0]   base_max;
  logic [SUMW-1:0] base_sum;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [CW:0]     top;
  logic [PW-1:0]   prefix_nxt;
  logic            hit;
  logic            last;
  logic [PW-1:0]   total_full;

  // Handshake
  assign in_ch.ready         = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.picked_index = out_index_r;
  assign out_ch.total_weight = out_total_r;

  // Load path: a load after draws starts from an empty set
  assign is_load    = (in_ch.op == OP_LOAD);
  assign cost_in    = CW'(in_ch.cost_value);
  assign base_count = drawing_r ? '0 : count_r;
  assign base_max   = drawing_r ? '0 : max_r;
  assign base_sum   = drawing_r ? '0 : sum_r;
  assign full       = (base_count == CNTW'(POP_SIZE));
  assign wr_en      = accept && is_load && !full;
  assign wr_addr    = base_count[IW-1:0];

  // Scan path: one stored cost per cycle into the prefix adder
  assign rd_en      = (accept && !is_load) || (state_r == S_SCAN);
  assign rd_addr    = (state_r == S_SCAN) ? j_r + IW'(1) : '0;
  assign top        = (CW + 1)'(max_r) + (CW + 1)'(WEIGHT_MARGIN);
  assign prefix_nxt = prefix_r + PW'(top) - PW'(rd_data_r);
  assign hit        = (CMPW'(draw_r) <= CMPW'(prefix_nxt)) && !marks_r[j_r];
  assign last       = ((CNTW'(j_r) + CNTW'(1)) == count_r);

  // Total weight from the settled state
  assign total_full = PW'(count_r) * PW'(top) - PW'(sum_r);

  // Memory: writes only on loads in idle, reads only on draws, never both
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cost_in;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer, set state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      drawing_r   <= 1'b0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_index_r <= '0;
            if (is_load) begin
              state_r <= S_DONE;
              if (full) begin
                out_status_r <= ST_FULL;
              end else begin
                out_status_r <= ST_LOADED;
                count_r      <= base_count + CNTW'(1);
                max_r        <= (cost_in > base_max) ? cost_in : base_max;
                sum_r        <= base_sum + SUMW'(cost_in);
                drawing_r    <= 1'b0;
                if (drawing_r) begin
                  marks_r <= '0;
                end
              end
            end else begin
              drawing_r <= 1'b1;
              draw_r    <= in_ch.draw_value;
              j_r       <= '0;
              prefix_r  <= '0;
              if (count_r == '0) begin
                out_status_r <= ST_MISS;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          // Mark the first reached unmarked entry, report a miss after the last, else advance
          if (hit) begin
            marks_r[j_r] <= 1'b1;
            out_status_r <= ST_PICKED;
            out_index_r  <= INDEX_W'(j_r);
            state_r      <= S_DONE;
          end else if (last) begin
            out_status_r <= ST_MISS;
            state_r      <= S_DONE;
          end else begin
            j_r      <= j_r + IW'(1);
            prefix_r <= prefix_nxt;
          end
        end
        S_DONE: begin
          out_total_r <= TOTAL_W'(total_full);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The store never holds more than POP_SIZE entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(POP_SIZE))
    else $error("loaded count above store depth");

  // A scan only visits loaded entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNTW'(j_r) < count_r))
    else $error("scan index beyond loaded entries");

  // A reported pick leaves its entry marked
  a_pick_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_PICKED && state_r == S_IDLE) |-> marks_r[j_r])
    else $error("picked entry not marked");

  // A dropped load leaves the set unchanged
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_load && full) |=> (count_r == $past(count_r) && sum_r == $past(sum_r)))
    else $error("dropped load changed the set");

endmodule

// File: tb/roulette_wheel_selector_tb.sv
// Testbench of the roulette wheel selector: stimulus, prediction and result checks.
module roulette_wheel_selector_tb;
  import rws_pkg::*;

  localparam int POP        = DEF_POP_SIZE;
  localparam int DRAW_TOP   = 2097280;
  localparam int COST_TOP   = 65535;
  localparam int ITEM_GOAL  = 1550;
  localparam int DRAIN_CYC  = 64;
  localparam int CYCLE_CAP  = 1200000;

  // One input word and one result word
  typedef struct {
    op_t               op;
    logic [COST_W-1:0] cost;
    logic [DRAW_W-1:0] draw;
  } word_t;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] idx;
    logic [TOTAL_W-1:0] total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  rws_in_if  in_ch ();
  rws_out_if out_ch ();

  roulette_wheel_selector #(
    .POP_SIZE  (DEF_POP_SIZE),
    .COST_BITS (DEF_COST_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  word_t   pending_words[$];
  result_t expected_results[$];
  word_t   next_word;
  result_t want;
  int      err_cnt = 0;
  int      item_cnt = 0;
  int      results_seen = 0;
  int      idle_left = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  int      next_hold_at = 200;
  int      send_calm = 0;
  int      recv_calm = 0;
  int      cycle_cnt = 0;

  // Wheel state as the block should hold it
  logic [COST_W-1:0] wheel_cost[POP];
  bit                wheel_mark[POP];
  int                n_loaded;
  logic [COST_W-1:0] peak_cost;
  logic [20:0]       sum_cost;
  bit                in_draws;

  function automatic void clear_wheel();
    for (int i = 0; i < POP; i++) wheel_mark[i] = 1'b0;
    n_loaded  = 0;
    peak_cost = '0;
    sum_cost  = '0;
    in_draws  = 1'b0;
  endfunction

  function automatic logic [TOTAL_W-1:0] wheel_total();
    longint t;
    t = longint'(n_loaded) * (longint'(peak_cost) + WEIGHT_MARGIN) - longint'(sum_cost);
    return t[TOTAL_W-1:0];
  endfunction

  // Apply one word to the wheel state and return the result it should give
  function automatic result_t spin_wheel(op_t op, logic [COST_W-1:0] cost,
                                         logic [DRAW_W-1:0] draw);
    result_t r;
    longint  top;
    longint  prefix;
    bit      hit;
    r.status = ST_MISS;
    r.idx    = '0;
    if (op == OP_LOAD) begin
      // a load after draws starts a new set
      if (in_draws) clear_wheel();
      if (n_loaded >= POP) begin
        r.status = ST_FULL;
      end else begin
        wheel_cost[n_loaded] = cost;
        n_loaded++;
        if (cost > peak_cost) peak_cost = cost;
        sum_cost = sum_cost + cost;
        r.status = ST_LOADED;
      end
    end else begin
      in_draws = 1'b1;
      top      = longint'(peak_cost) + WEIGHT_MARGIN;
      prefix   = 0;
      hit      = 1'b0;
      for (int j = 0; j < n_loaded && !hit; j++) begin
        prefix += top - longint'(wheel_cost[j]);
        if (longint'(draw) <= prefix && !wheel_mark[j]) begin
          wheel_mark[j] = 1'b1;
          r.idx    = j[INDEX_W-1:0];
          r.status = ST_PICKED;
          hit      = 1'b1;
        end
      end
    end
    r.total = wheel_total();
    return r;
  endfunction

  // Mostly short gaps, a few long ones, now and then a run with none
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(40, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // Queue one word; the unused field gets random bits
  task automatic queue_word(op_t op, int unsigned val);
    word_t w;
    w.op   = op;
    w.cost = (op == OP_LOAD) ? val[COST_W-1:0] : COST_W'($urandom_range(0, COST_TOP));
    w.draw = (op == OP_DRAW) ? val[DRAW_W-1:0] : DRAW_W'($urandom_range(0, DRAW_TOP));
    pending_words = {pending_words, w};
    item_cnt++;
  endtask

  // Load one set of costs, then draw against it
  task automatic queue_set(int n, int mode, int n_draws);
    int     c;
    int     fixed;
    int     kept;
    int     peak;
    int     r;
    longint sum;
    longint total;
    kept  = 0;
    peak  = 0;
    sum   = 0;
    fixed = $urandom_range(0, COST_TOP);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: c = $urandom_range(0, COST_TOP);
        1: c = $urandom_range(0, 15);
        2: c = fixed;
        default: c = $urandom_range(0, 1) ? COST_TOP : 0;
      endcase
      queue_word(OP_LOAD, c);
      if (kept < POP) begin
        kept++;
        if (c > peak) peak = c;
        sum += c;
      end
    end
    total = longint'(kept) * (peak + WEIGHT_MARGIN) - sum;
    for (int k = 0; k < n_draws; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) queue_word(OP_DRAW, $urandom_range(0, int'(total)));
      else if (r < 85) queue_word(OP_DRAW, int'(total));
      else queue_word(OP_DRAW, $urandom_range(int'(total) + 1, DRAW_TOP));
    end
  endtask

  // Driver: offer pending words, hold a word until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      idle_left   <= 0;
      clear_wheel();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results = {expected_results,
          spin_wheel(in_ch.op, in_ch.cost_value, in_ch.draw_value)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_left != 0) begin
          idle_left   <= idle_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.op         <= next_word.op;
          in_ch.cost_value <= next_word.cost;
          in_ch.draw_value <= next_word.draw;
          idle_left        <= pick_idle(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: status %0d index %0d total %0d",
                   $time, out_ch.status, out_ch.picked_index, out_ch.total_weight);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_ch.status);
            err_cnt++;
          end
          if (out_ch.picked_index !== want.idx) begin
            $display("%0t: picked_index expected %0d actual %0d",
                     $time, want.idx, out_ch.picked_index);
            err_cnt++;
          end
          if (out_ch.total_weight !== want.total) begin
            $display("%0t: total_weight expected %0d actual %0d",
                     $time, want.total, out_ch.total_weight);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left   <= pick_idle(recv_calm);
      end
    end
  end

  // Long receiver hold-off now and then, so the block stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= $urandom_range(150, 300);
      next_hold_at <= next_hold_at + 500;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("roulette_wheel_selector_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int mode;
    int n;
    int r;
    rst_n = 1'b0;

    // Directed: draws on an empty store
    queue_word(OP_DRAW, 0);
    queue_word(OP_DRAW, DRAW_TOP);
    // Load after draws, cost extremes: weights 65540 and 5, total 65545
    queue_word(OP_LOAD, 0);
    queue_word(OP_LOAD, COST_TOP);
    queue_word(OP_DRAW, 65545);
    queue_word(OP_DRAW, 65545);
    queue_word(OP_DRAW, 0);
    queue_word(OP_DRAW, 0);
    queue_word(OP_DRAW, 65546);
    // Fill the store, then one load too many
    for (int i = 0; i < POP; i++)
      queue_word(OP_LOAD, (i == 5) ? COST_TOP : ((i % 2) ? 16'hAAAA : 16'h5555));
    queue_word(OP_LOAD, 16'h1234);
    queue_word(OP_DRAW, 2097152);
    queue_word(OP_DRAW, 0);
    queue_word(OP_DRAW, 1005030);

    // Random sets: mostly small, some full or overfull
    while (item_cnt < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(1, 8);
      else if (r < 85) n = $urandom_range(9, POP - 1);
      else n = $urandom_range(POP, POP + 2);
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : mode - 5;
      queue_set(n, mode, $urandom_range(1, n + 4));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("roulette_wheel_selector_tb: PASS");
    end else begin
      $display("roulette_wheel_selector_tb: FAIL");
    end
    $finish;
  end

endmodule
